FILE: rtl/path_match_position_stats_top_defines.svh
// assertion macros for the top rtl file
`ifndef PATH_MATCH_POSITION_STATS_TOP_DEFINES_SVH
`define PATH_MATCH_POSITION_STATS_TOP_DEFINES_SVH

// plain property, sampled on clk, off during reset
`define PMPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication from one cycle to the next
`define PMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pmps_pkg.sv
// ----------------------------------------------------------------------------
// pmps_pkg
// constants and helpers for the path match position stats block
// ----------------------------------------------------------------------------
`default_nettype none
package pmps_pkg;
	localparam logic [1:0] OP_PATH    = 2'd0;
	localparam logic [1:0] OP_RANGE   = 2'd1;
	localparam logic [1:0] OP_PATTERN = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam int RESULT_LIMIT = 32;
	// path index width: start plus a saturated offset of up to 256
	localparam int IW = 10;

	function automatic logic is_letter(input logic [7:0] ch);
		return (ch >= CH_UA && ch <= CH_UZ) || (ch >= CH_LA && ch <= CH_LZ);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/pmps_ram.sv
// ----------------------------------------------------------------------------
// pmps_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module pmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/path_match_position_stats_top.sv
// ----------------------------------------------------------------------------
// path_match_position_stats_top
// loads a path, match ranges and a query pattern, then reports per-range
// position features for ranking fuzzy path matches
// ----------------------------------------------------------------------------
// One word is handled at a time. Path and range words are taken when idle; a
// pattern word that extends a segment then goes through range read, path read
// and update. A compute word walks the path ram byte by byte (registered read,
// then evaluate) for the depth count, then per range back and ahead, with any
// wait on out_ready. The back run ends at '/' or the path start, the ahead run
// at '/', a zero byte or the path end. No clearing pass is needed after reset.
`default_nettype none
module path_match_position_stats_top #(
	parameter int PATH_MAX   = 256,
	parameter int MAX_RANGES = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] char_in,
	input  wire logic [7:0] range_start,
	input  wire logic [7:0] range_end,
	input  wire logic       word_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      range_index,
	output logic [7:0]      depth,
	output logic [7:0]      dir_back,
	output logic [7:0]      dir_ahead,
	output logic [7:0]      word_back,
	output logic [7:0]      word_ahead,
	output logic [7:0]      mismatches,
	output logic            last
);
	import pmps_pkg::*;

	localparam int LW = $clog2(PATH_MAX + 1);
	localparam int AW = $clog2(PATH_MAX);
	localparam int RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_P_RNG = 4'd1;
	localparam logic [3:0] ST_P_PTH = 4'd2;
	localparam logic [3:0] ST_P_UPD = 4'd3;
	localparam logic [3:0] ST_D_A   = 4'd4;
	localparam logic [3:0] ST_D_E   = 4'd5;
	localparam logic [3:0] ST_D_ONE = 4'd6;
	localparam logic [3:0] ST_K_ST  = 4'd7;
	localparam logic [3:0] ST_K_LD  = 4'd8;
	localparam logic [3:0] ST_B_A   = 4'd9;
	localparam logic [3:0] ST_B_E   = 4'd10;
	localparam logic [3:0] ST_A_A   = 4'd11;
	localparam logic [3:0] ST_A_E   = 4'd12;
	localparam logic [3:0] ST_EMIT  = 4'd13;

	logic [3:0]  state_q;
	logic [LW-1:0] len_q, i_q;
	logic [CW-1:0] rc_q, seg_q, k_q, n_w;
	logic [8:0]  off_q, d_q;
	logic [7:0]  ch_q, depth_q, st_q, en_q, mm_q, db_q, wb_q, da_q, wa_q;
	logic        wend_q, wdone_q, inr_q;
	logic [MAX_RANGES-1:0] mv_q;

	logic          p_we, r_we, m_we;
	logic [AW-1:0] p_raddr;
	logic [7:0]    p_rdata, m_wdata, m_rdata;
	logic [RW-1:0] r_raddr, m_raddr, m_waddr;
	logic [15:0]   r_rdata;
	logic [IW-1:0] idx_w;
	logic [7:0]    pch_w, mval_w;
	logic          in_acc, out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign n_w = (int'(rc_q) > RESULT_LIMIT) ? CW'(RESULT_LIMIT) : rc_q;
	assign pch_w  = inr_q ? p_rdata : 8'd0;
	assign mval_w = mv_q[m_raddr] ? m_rdata : 8'd0;

	assign p_we    = in_acc && (op == OP_PATH) && (int'(len_q) < PATH_MAX);
	assign r_we    = in_acc && (op == OP_RANGE) && (int'(rc_q) < MAX_RANGES);
	assign m_we    = (state_q == ST_P_UPD);
	assign m_waddr = seg_q[RW-1:0];
	assign m_wdata = (pch_w != ch_q && mval_w != 8'hFF) ? mval_w + 8'd1 : mval_w;

	// path index for the current scan step
	always_comb begin
		case (state_q)
			ST_P_PTH: idx_w = IW'(r_rdata[15:8]) + IW'(off_q);
			ST_D_A:   idx_w = (len_q == LW'(1)) ? '0 : IW'(i_q);
			ST_B_A:   idx_w = IW'(st_q - d_q[7:0]);
			ST_A_A:   idx_w = IW'(en_q) + IW'(d_q);
			default:  idx_w = '0;
		endcase
	end
	assign p_raddr = idx_w[AW-1:0];
	assign r_raddr = (state_q == ST_K_ST) ? k_q[RW-1:0] : seg_q[RW-1:0];
	assign m_raddr = r_raddr;

	pmps_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_path_ram (
		.clk(clk), .we(p_we), .waddr(len_q[AW-1:0]), .wdata(char_in),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	pmps_ram #(.WIDTH(16), .DEPTH(MAX_RANGES)) u_range_ram (
		.clk(clk), .we(r_we), .waddr(rc_q[RW-1:0]), .wdata({range_start, range_end}),
		.raddr(r_raddr), .rdata(r_rdata)
	);
	pmps_ram #(.WIDTH(8), .DEPTH(MAX_RANGES)) u_mm_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			rc_q      <= '0;
			seg_q     <= '0;
			off_q     <= '0;
			mv_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			inr_q <= (idx_w < IW'(len_q));
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ch_q   <= char_in;
						wend_q <= word_last;
						case (op)
							OP_PATH: if (int'(len_q) < PATH_MAX) len_q <= len_q + LW'(1);
							OP_RANGE: if (int'(rc_q) < MAX_RANGES) rc_q <= rc_q + CW'(1);
							OP_PATTERN: begin
								if (char_in == CH_SLASH) begin
									// slash closes a segment, word end one more
									if (word_last && seg_q + CW'(1) < rc_q) seg_q <= seg_q + CW'(2);
									else if (seg_q < rc_q) seg_q <= seg_q + CW'(1);
									off_q <= '0;
								end else if (seg_q < rc_q) begin
									state_q <= ST_P_RNG;
								end else if (word_last) begin
									off_q <= '0;
								end
							end
							OP_COMPUTE: begin
								depth_q <= 8'd1;
								i_q     <= LW'(1);
								k_q     <= '0;
								state_q <= ST_D_A;
							end
							default: ;
						endcase
					end
				end
				ST_P_RNG: state_q <= ST_P_PTH;
				ST_P_PTH: state_q <= ST_P_UPD;
				ST_P_UPD: begin
					mv_q[m_waddr] <= 1'b1;
					if (wend_q) begin
						seg_q <= seg_q + CW'(1);
						off_q <= '0;
					end else if (off_q != 9'd256) begin
						off_q <= off_q + 9'd1;
					end
					state_q <= ST_IDLE;
				end
				ST_D_A: begin
					if (len_q == '0) begin
						depth_q <= 8'd0;
						state_q <= ST_K_ST;
					end else if (len_q == LW'(1)) begin
						state_q <= ST_D_ONE;
					end else if (i_q + LW'(1) < len_q) begin
						state_q <= ST_D_E;
					end else begin
						state_q <= ST_K_ST;
					end
				end
				ST_D_E: begin
					if (p_rdata == CH_SLASH && depth_q != 8'hFF) depth_q <= depth_q + 8'd1;
					i_q     <= i_q + LW'(1);
					state_q <= ST_D_A;
				end
				ST_D_ONE: begin
					depth_q <= (p_rdata != CH_SLASH) ? 8'd1 : 8'd0;
					state_q <= ST_K_ST;
				end
				ST_K_ST: begin
					if (k_q == n_w) begin
						len_q   <= '0;
						rc_q    <= '0;
						seg_q   <= '0;
						off_q   <= '0;
						mv_q    <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_K_LD;
					end
				end
				ST_K_LD: begin
					st_q    <= r_rdata[15:8];
					en_q    <= r_rdata[7:0];
					// ram was read at k_q in the previous cycle
					mm_q    <= mv_q[k_q[RW-1:0]] ? m_rdata : 8'd0;
					d_q     <= '0;
					wdone_q <= 1'b0;
					state_q <= ST_B_A;
				end
				ST_B_A: begin
					if (d_q > {1'b0, st_q}) begin
						// ran off the path start
						if (!wdone_q) wb_q <= d_q[7:0] - 8'd1;
						db_q    <= d_q[7:0] - 8'd1;
						d_q     <= '0;
						wdone_q <= 1'b0;
						state_q <= ST_A_A;
					end else begin
						state_q <= ST_B_E;
					end
				end
				ST_B_E: begin
					if (!wdone_q && !is_letter(pch_w)) begin
						wb_q    <= d_q[7:0] - 8'd1;
						wdone_q <= 1'b1;
					end
					if (pch_w == CH_SLASH) begin
						db_q    <= d_q[7:0] - 8'd1;
						d_q     <= '0;
						wdone_q <= 1'b0;
						state_q <= ST_A_A;
					end else begin
						d_q     <= d_q + 9'd1;
						state_q <= ST_B_A;
					end
				end
				ST_A_A: state_q <= ST_A_E;
				ST_A_E: begin
					if (!wdone_q && !is_letter(pch_w)) begin
						wa_q    <= d_q[8] ? 8'hFF : d_q[7:0];
						wdone_q <= 1'b1;
					end
					if (pch_w == 8'd0 || pch_w == CH_SLASH) begin
						da_q    <= d_q[8] ? 8'hFF : d_q[7:0];
						state_q <= ST_EMIT;
					end else begin
						d_q     <= d_q + 9'd1;
						state_q <= ST_A_A;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						k_q     <= k_q + CW'(1);
						state_q <= ST_K_ST;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			range_index <= 5'(k_q);
			depth       <= depth_q;
			dir_back    <= db_q;
			dir_ahead   <= da_q;
			word_back   <= wb_q;
			word_ahead  <= wa_q;
			mismatches  <= mm_q;
			last        <= (k_q + CW'(1) == n_w);
		end
	end

	`include "path_match_position_stats_top_defines.svh"

	`PMPS_ASSERT(a_seg_bound, seg_q <= rc_q, "segment number past range count")
	`PMPS_ASSERT(a_len_bound, int'(len_q) <= PATH_MAX, "path length past path memory")
	`PMPS_ASSERT_NEXT(a_emit_next, out_load, state_q == ST_K_ST && out_valid,
		"emit did not return to range loop")
	`PMPS_ASSERT(a_no_emit_idle, !(state_q == ST_IDLE && out_load), "emit outside compute")
endmodule
`default_nettype wire

FILE: dv/path_match_position_stats_top_tb.sv
// ----------------------------------------------------------------------------
// path_match_position_stats_top_tb
// self-checking bench: loads paths, ranges and patterns, runs computes and
// compares every reported range against a scoreboard that tracks the block
// ----------------------------------------------------------------------------
`default_nettype none
module path_match_position_stats_top_tb;
	import pmps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PATH_CAP  = 256;
	localparam int RANGE_CAP = 32;
	localparam int STALL_LIMIT = 40000;

	typedef struct packed {
		logic [4:0] idx;
		logic [7:0] dep;
		logic [7:0] dback;
		logic [7:0] dahead;
		logic [7:0] wback;
		logic [7:0] wahead;
		logic [7:0] mism;
		logic       fin;
	} range_stats_t;

	class range_stats_board;
		logic [7:0] path_mem [PATH_CAP];
		int unsigned path_len;
		logic [7:0] start_mem [RANGE_CAP];
		logic [7:0] end_mem [RANGE_CAP];
		int unsigned n_ranges;
		logic [7:0] seg_miss [RANGE_CAP];
		int unsigned seg_num;
		int unsigned seg_off;
		range_stats_t pending [$];
		int errors;

		function void clear_query();
			path_len = 0;
			n_ranges = 0;
			seg_num = 0;
			seg_off = 0;
			foreach (seg_miss[i]) seg_miss[i] = '0;
		endfunction

		function logic [7:0] byte_at(int unsigned i);
			return (i < path_len) ? path_mem[i] : 8'h00;
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
		endfunction

		function logic [7:0] walk_back(int unsigned c, bit letters);
			int unsigned d;
			logic [7:0] ch;
			d = 0;
			while (d <= c) begin
				ch = byte_at(c - d);
				if (letters ? !letter(ch) : ch == CH_SLASH) break;
				d++;
			end
			return 8'(d - 1);
		endfunction

		function logic [7:0] walk_ahead(int unsigned c, bit letters);
			int unsigned d;
			logic [7:0] ch;
			d = 0;
			forever begin
				ch = byte_at(c + d);
				if (ch == 8'h00) break;
				if (letters ? !letter(ch) : ch == CH_SLASH) break;
				d++;
			end
			return (d > 255) ? 8'd255 : 8'(d);
		endfunction

		function void close_seg();
			if (seg_num < n_ranges) seg_num++;
			seg_off = 0;
		endfunction

		function void note_word(logic [1:0] op, logic [7:0] ch, logic [7:0] rs,
				logic [7:0] re, logic we);
			int unsigned n;
			int unsigned dep;
			range_stats_t r;
			case (op)
				OP_PATH: begin
					if (path_len < PATH_CAP) path_mem[path_len++] = ch;
				end
				OP_RANGE: begin
					if (n_ranges < RANGE_CAP) begin
						start_mem[n_ranges] = rs;
						end_mem[n_ranges] = re;
						n_ranges++;
					end
				end
				OP_PATTERN: begin
					if (ch == CH_SLASH) close_seg();
					else if (seg_num < n_ranges) begin
						if (byte_at(start_mem[seg_num] + seg_off) != ch &&
								seg_miss[seg_num] != 8'hFF)
							seg_miss[seg_num]++;
						if (seg_off < 256) seg_off++;
					end
					if (we) close_seg();
				end
				default: begin
					n = n_ranges;
					if (path_len == 0) dep = 0;
					else if (path_len == 1) dep = (byte_at(0) != CH_SLASH);
					else begin
						dep = 1;
						for (int i = 1; i + 1 < path_len; i++)
							if (byte_at(i) == CH_SLASH) dep++;
						if (dep > 255) dep = 255;
					end
					for (int k = 0; k < n; k++) begin
						r.idx = 5'(k);
						r.dep = 8'(dep);
						r.dback = walk_back(start_mem[k], 1'b0);
						r.dahead = walk_ahead(end_mem[k], 1'b0);
						r.wback = walk_back(start_mem[k], 1'b1);
						r.wahead = walk_ahead(end_mem[k], 1'b1);
						r.mism = seg_miss[k];
						r.fin = (k + 1 == n);
						pending.push_back(r);
					end
					clear_query();
				end
			endcase
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
			errors++;
		endtask

		task check(range_stats_t got);
			range_stats_t w;
			if (pending.size() == 0) begin
				report("unexpected word, range_index", 8'(got.idx), 8'hxx);
				return;
			end
			w = pending.pop_front();
			if (got.idx !== w.idx) report("range_index", 8'(got.idx), 8'(w.idx));
			if (got.dep !== w.dep) report("depth", got.dep, w.dep);
			if (got.dback !== w.dback) report("dir_back", got.dback, w.dback);
			if (got.dahead !== w.dahead) report("dir_ahead", got.dahead, w.dahead);
			if (got.wback !== w.wback) report("word_back", got.wback, w.wback);
			if (got.wahead !== w.wahead) report("word_ahead", got.wahead, w.wahead);
			if (got.mism !== w.mism) report("mismatches", got.mism, w.mism);
			if (got.fin !== w.fin) report("last", 8'(got.fin), 8'(w.fin));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] op;
	logic [7:0] char_in;
	logic [7:0] range_start;
	logic [7:0] range_end;
	logic       word_last;
	logic       out_valid;
	logic       out_ready;
	logic [4:0] range_index;
	logic [7:0] depth;
	logic [7:0] dir_back;
	logic [7:0] dir_ahead;
	logic [7:0] word_back;
	logic [7:0] word_ahead;
	logic [7:0] mismatches;
	logic       last;

	path_match_position_stats_top dut (.*);

	range_stats_board board = new();
	int burst_left;
	int sent_words;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// send one word and hold it until accepted
	task send(logic [1:0] o, logic [7:0] ch, logic [7:0] rs, logic [7:0] re, logic we);
		op <= o;
		char_in <= ch;
		range_start <= rs;
		range_end <= re;
		word_last <= we;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_word(o, ch, rs, re, we);
		sent_words++;
		if (burst_left > 0) burst_left--;
		else begin
			in_valid <= 1'b0;
			burst_left = $urandom_range(0, 12);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task load_path(string s);
		foreach (s[i]) send(OP_PATH, s[i], 8'h00, 8'h00, 1'b0);
	endtask

	task load_pattern(string s, bit we_last);
		foreach (s[i]) send(OP_PATTERN, s[i], 8'h00, 8'h00, we_last && i == s.len() - 1);
	endtask

	function logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0: return CH_SLASH;
			1: return 8'($urandom_range(0, 255));
			2: return 8'($urandom_range(CH_UA, CH_UZ));
			default: return 8'($urandom_range(CH_LA, CH_LZ));
		endcase
	endfunction

	// one well-formed query with random content
	task random_query();
		int len;
		int nr;
		logic [7:0] rs;
		logic [7:0] pc;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
		nr = $urandom_range(0, 5);
		for (int i = 0; i < len; i++) send(OP_PATH, pick_char(), 8'h00, 8'h00, 1'b0);
		for (int k = 0; k < nr; k++) begin
			rs = ($urandom_range(0, 7) == 0 || len == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, len - 1));
			send(OP_RANGE, 8'($urandom), rs, ($urandom_range(0, 7) == 0) ?
				8'($urandom_range(0, 255)) : 8'(rs + $urandom_range(0, 4)),
				1'($urandom));
		end
		for (int k = 0; k < nr + $urandom_range(0, 1); k++) begin
			for (int j = $urandom_range(0, 4); j > 0; j--) begin
				pc = board.byte_at(board.start_mem[board.seg_num] + board.seg_off);
				if ($urandom_range(0, 3) == 0 || board.seg_num >= board.n_ranges)
					pc = pick_char();
				send(OP_PATTERN, pc, 8'($urandom), 8'($urandom), 1'b0);
			end
			if ($urandom_range(0, 1)) send(OP_PATTERN, CH_SLASH, 8'h00, 8'h00, 1'($urandom));
			else send(OP_PATTERN, 8'($urandom_range(CH_LA, CH_LZ)), 8'h00, 8'h00, 1'b1);
		end
		// sometimes one noise word, compute always last
		if ($urandom_range(0, 3) == 0)
			send(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom), 8'($urandom),
				1'($urandom));
		send(OP_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// receiver: stalls in randomly chosen modes, with all-ready stretches
	int ready_mode;
	int ready_left;
	int ready_tick;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_mode = 0;
			ready_left = 0;
			ready_tick = 0;
		end else begin
			if (out_valid && out_ready)
				board.check({range_index, depth, dir_back, dir_ahead, word_back,
					word_ahead, mismatches, last});
			if (ready_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_left = $urandom_range(10, 60);
			end
			ready_left--;
			ready_tick++;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom);
				2: out_ready <= (ready_tick % 4 == 0);
				default: out_ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PATH;
		char_in = '0;
		range_start = '0;
		range_end = '0;
		word_last = 1'b0;
		burst_left = 0;
		sent_words = 0;
		idle_cycles = 0;
		board.clear_query();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// compute with nothing loaded, then one-byte paths
		send(OP_COMPUTE, 8'h00, 8'h00, 8'h00, 1'b0);
		load_path("/");
		send(OP_RANGE, 8'h00, 8'h00, 8'h01, 1'b0);
		send(OP_COMPUTE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		load_path("x");
		send(OP_RANGE, 8'h00, 8'h00, 8'h00, 1'b0);
		send(OP_COMPUTE, 8'h00, 8'h00, 8'h00, 1'b0);

		// start on a slash, start on a non-letter, ranges past the path
		load_path("/ab/C9z");
		send(OP_RANGE, 8'h00, 8'h03, 8'h05, 1'b0);
		send(OP_RANGE, 8'h00, 8'h05, 8'h07, 1'b0);
		send(OP_RANGE, 8'h00, 8'hFF, 8'hFF, 1'b0);
		// slash with word end closes an extra empty segment; surplus ignored
		send(OP_PATTERN, "C", 8'h00, 8'h00, 1'b0);
		send(OP_PATTERN, CH_SLASH, 8'h00, 8'h00, 1'b1);
		load_pattern("zq", 1'b1);
		load_pattern("qqq", 1'b0);
		send(OP_COMPUTE, 8'h00, 8'h00, 8'h00, 1'b0);

		// full range list, ranges mostly past a short path
		load_path("ab/cd");
		for (int k = 0; k < RANGE_CAP + 2; k++)
			send(OP_RANGE, 8'h00, 8'(k * 8), 8'(255 - k * 8), 1'b0);
		load_pattern("abxq", 1'b1);
		send(OP_COMPUTE, 8'h00, 8'h00, 8'h00, 1'b0);

		while (sent_words < 100) random_query();

		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
